### hw/rtl/ssw_pkg.sv
// Shared types and constants for the stream stall watchdog.
`timescale 1ns / 1ps

package ssw_pkg;

  localparam int unsigned TimeW    = 64;
  localparam int unsigned CfgW     = 32;
  localparam int unsigned CfgIdxW  = 4;
  localparam int unsigned ActionW  = 2;

  localparam logic [CfgW-1:0] ThresholdReset = 32'd2000;
  localparam logic [CfgW-1:0] IntervalReset  = 32'd10000;

  localparam logic [CfgIdxW-1:0] RegThreshold = 4'd0;
  localparam logic [CfgIdxW-1:0] RegInterval  = 4'd1;

  typedef enum logic [ActionW-1:0] {
    ACT_NONE      = 2'd0,
    ACT_START     = 2'd1,
    ACT_ONGOING   = 2'd2,
    ACT_RECOVERED = 2'd3
  } action_e;

  typedef struct packed {
    logic [CfgW-1:0] stall_threshold;
    logic [CfgW-1:0] report_interval;
  } cfg_t;

endpackage

### hw/rtl/ssw_if.sv
// Stream channel interfaces for observation requests and watchdog reports.
`timescale 1ns / 1ps

interface ssw_req_if;
  logic                      valid;
  logic                      ready;
  logic                      req_type;
  logic [ssw_pkg::TimeW-1:0] now_time;
  logic                      stream_valid;

  modport source (output valid, output req_type, output now_time, output stream_valid,
                  input ready);
  modport sink (input valid, input req_type, input now_time, input stream_valid,
                output ready);
endinterface

interface ssw_rpt_if;
  logic                        valid;
  logic                        ready;
  logic [ssw_pkg::ActionW-1:0] action;
  logic [ssw_pkg::TimeW-1:0]   elapsed_time;

  modport source (output valid, output action, output elapsed_time, input ready);
  modport sink (input valid, input action, input elapsed_time, output ready);
endinterface

### hw/rtl/ssw_cfg.sv
// Configuration register file: stall threshold and report interval.
`timescale 1ns / 1ps

module ssw_cfg (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [ssw_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [ssw_pkg::CfgW-1:0]      cfg_wdata_i,
  output ssw_pkg::cfg_t                 cfg_o
);
  import ssw_pkg::*;

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        RegThreshold: cfg_d.stall_threshold = cfg_wdata_i;
        RegInterval:  cfg_d.report_interval = cfg_wdata_i;
        default:      cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.stall_threshold <= ThresholdReset;
      cfg_q.report_interval <= IntervalReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

### hw/rtl/ssw_eval.sv
// Stall tracking state and per-beat decision logic.
`timescale 1ns / 1ps

module ssw_eval (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          step_i,
  input  logic                          req_type_i,
  input  logic [ssw_pkg::TimeW-1:0]     now_time_i,
  input  logic                          stream_valid_i,
  input  ssw_pkg::cfg_t                 cfg_i,
  output ssw_pkg::action_e              action_o,
  output logic [ssw_pkg::TimeW-1:0]     elapsed_o
);
  import ssw_pkg::*;

  logic             stall_q, stall_d;
  logic [TimeW-1:0] last_good_q, last_good_d;
  logic [TimeW-1:0] begin_q, begin_d;
  logic [TimeW-1:0] report_q, report_d;

  logic [TimeW-1:0] idle;
  logic [TimeW-1:0] dur;
  logic [TimeW-1:0] since_rpt;
  logic             idle_hit;
  logic             rpt_hit;

  assign idle      = (now_time_i >= last_good_q) ? now_time_i - last_good_q : '0;
  assign dur       = (now_time_i >= begin_q) ? now_time_i - begin_q : '0;
  assign since_rpt = now_time_i - report_q;
  assign idle_hit  = idle >= {{(TimeW-CfgW){1'b0}}, cfg_i.stall_threshold};
  assign rpt_hit   = (now_time_i >= report_q) &&
                     (since_rpt >= {{(TimeW-CfgW){1'b0}}, cfg_i.report_interval});

  always_comb begin
    stall_d     = stall_q;
    last_good_d = last_good_q;
    begin_d     = begin_q;
    report_d    = report_q;
    action_o    = ACT_NONE;
    elapsed_o   = '0;
    if (req_type_i) begin
      stall_d     = 1'b0;
      last_good_d = now_time_i;
      begin_d     = '0;
      report_d    = '0;
    end else if (stream_valid_i) begin
      if (stall_q) begin
        action_o  = ACT_RECOVERED;
        elapsed_o = dur;
        stall_d   = 1'b0;
        begin_d   = '0;
        report_d  = '0;
      end
      last_good_d = now_time_i;
    end else if (!stall_q) begin
      if (idle_hit) begin
        stall_d   = 1'b1;
        begin_d   = last_good_q;
        report_d  = now_time_i;
        action_o  = ACT_START;
        elapsed_o = idle;
      end
    end else if (rpt_hit) begin
      report_d  = now_time_i;
      action_o  = ACT_ONGOING;
      elapsed_o = dur;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stall_q     <= 1'b0;
      last_good_q <= '0;
      begin_q     <= '0;
      report_q    <= '0;
    end else if (step_i) begin
      stall_q     <= stall_d;
      last_good_q <= last_good_d;
      begin_q     <= begin_d;
      report_q    <= report_d;
    end
  end

  a_restart_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && req_type_i |=> !stall_q && begin_q == '0 && report_q == '0)
    else $error("restart left stall state set");

  a_ongoing_in_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && (action_o == ACT_ONGOING || action_o == ACT_RECOVERED) |-> stall_q)
    else $error("stall report outside an active stall");

  a_start_sets_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && action_o == ACT_START |=> stall_q && report_q == $past(now_time_i))
    else $error("stall start did not arm the stall");

endmodule

### hw/rtl/stream_stall_watchdog.sv
// Top level of the stream stall watchdog: input stage, evaluation, report register.
//
//  channel  | dir | payload                              | beat
//  ---------+-----+--------------------------------------+---------------------
//  req      | in  | req_type, now_time[63:0], stream_valid | valid & ready
//  rpt      | out | action[1:0], elapsed_time[63:0]      | valid & ready
//  cfg      | in  | cfg_idx_i, cfg_wdata_i[31:0]         | cfg_we_i
//
//  One beat per cycle sustained while reports are taken; a taken request passes through
//  the input register, then evaluation into the report register.
//  Reset loads threshold 2000 and interval 10000 and clears the stall state.
//  A stalled report holds the input stage; req ready drops only when both stages
//  are full and the report is not taken in that cycle.
`timescale 1ns / 1ps

module stream_stall_watchdog (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  ssw_req_if.sink                       in_i,
  ssw_rpt_if.source                     out_o,
  input  logic                          cfg_we_i,
  input  logic [ssw_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [ssw_pkg::CfgW-1:0]      cfg_wdata_i
);
  import ssw_pkg::*;

  cfg_t             cfg;
  logic             s1_valid_q;
  logic             s1_req_q;
  logic [TimeW-1:0] s1_now_q;
  logic             s1_sv_q;
  logic             out_valid_q;
  action_e          out_action_q;
  logic [TimeW-1:0] out_elapsed_q;
  action_e          action;
  logic [TimeW-1:0] elapsed;
  logic             advance;
  logic             step;

  assign advance  = !out_valid_q || out_o.ready;
  assign step     = s1_valid_q && advance;
  assign in_i.ready = !s1_valid_q || advance;

  ssw_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  ssw_eval u_eval (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .step_i         (step),
    .req_type_i     (s1_req_q),
    .now_time_i     (s1_now_q),
    .stream_valid_i (s1_sv_q),
    .cfg_i          (cfg),
    .action_o       (action),
    .elapsed_o      (elapsed)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_i.ready) begin
        s1_valid_q <= in_i.valid;
      end
      if (advance) begin
        out_valid_q <= s1_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      s1_req_q <= in_i.req_type;
      s1_now_q <= in_i.now_time;
      s1_sv_q  <= in_i.stream_valid;
    end
    if (step) begin
      out_action_q  <= action;
      out_elapsed_q <= elapsed;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.action       = out_action_q;
  assign out_o.elapsed_time = out_elapsed_q;

  a_stage_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && !advance |=> s1_valid_q && $stable(s1_now_q))
    else $error("input stage lost a beat while the report was stalled");

  a_none_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_action_q == ACT_NONE |-> out_elapsed_q == '0)
    else $error("no-action report carries a nonzero elapsed time");

  a_step_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step |=> out_valid_q)
    else $error("evaluated beat did not reach the report register");

endmodule

### verif/stream_stall_watchdog_checker.sv
// Checker for the stream stall watchdog: predicts each report and compares it field by field.
`timescale 1ns / 1ps

module stream_stall_watchdog_checker (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  ssw_req_if                           req_mon,
  ssw_rpt_if                           rpt_mon,
  input  logic                         cfg_we_i,
  input  logic [ssw_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [ssw_pkg::CfgW-1:0]     cfg_wdata_i,
  output int unsigned                  mismatch_cnt_o,
  output int unsigned                  pending_o
);
  import ssw_pkg::*;

  typedef struct packed {
    action_e           action;
    logic [TimeW-1:0]  elapsed;
  } report_t;

  report_t expected_reports[$];

  logic              stall_on;
  logic [TimeW-1:0]  good_ts;
  logic [TimeW-1:0]  stall_ts;
  logic [TimeW-1:0]  report_ts;
  logic [CfgW-1:0]   thr;
  logic [CfgW-1:0]   ivl;
  int unsigned       errs;

  function automatic logic [TimeW-1:0] sat_sub(logic [TimeW-1:0] a, logic [TimeW-1:0] b);
    return (a >= b) ? a - b : '0;
  endfunction

  function automatic report_t predict_report(logic restart, logic [TimeW-1:0] now,
                                             logic svalid);
    report_t          r;
    logic [TimeW-1:0] idle;
    r.action  = ACT_NONE;
    r.elapsed = '0;
    if (restart) begin
      stall_on  = 1'b0;
      good_ts   = now;
      stall_ts  = '0;
      report_ts = '0;
    end else if (svalid) begin
      if (stall_on) begin
        r.action  = ACT_RECOVERED;
        r.elapsed = sat_sub(now, stall_ts);
        stall_on  = 1'b0;
        stall_ts  = '0;
        report_ts = '0;
      end
      good_ts = now;
    end else if (!stall_on) begin
      idle = sat_sub(now, good_ts);
      if (idle >= TimeW'(thr)) begin
        stall_on  = 1'b1;
        stall_ts  = good_ts;
        report_ts = now;
        r.action  = ACT_START;
        r.elapsed = idle;
      end
    end else if (now >= report_ts && now - report_ts >= TimeW'(ivl)) begin
      report_ts = now;
      r.action  = ACT_ONGOING;
      r.elapsed = sat_sub(now, stall_ts);
    end
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : monitor
    report_t got;
    report_t want;
    if (!rst_ni) begin
      stall_on  = 1'b0;
      good_ts   = '0;
      stall_ts  = '0;
      report_ts = '0;
      thr       = ThresholdReset;
      ivl       = IntervalReset;
      errs      = 0;
      expected_reports.delete();
      mismatch_cnt_o <= 0;
      pending_o      <= 0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == RegThreshold) begin
          thr = cfg_wdata_i;
        end else if (cfg_idx_i == RegInterval) begin
          ivl = cfg_wdata_i;
        end
      end
      if (req_mon.valid && req_mon.ready) begin
        expected_reports.push_back(predict_report(req_mon.req_type, req_mon.now_time,
                                                  req_mon.stream_valid));
      end
      if (rpt_mon.valid && rpt_mon.ready) begin
        got.action  = action_e'(rpt_mon.action);
        got.elapsed = rpt_mon.elapsed_time;
        if (expected_reports.size() == 0) begin
          $display("%0t: unexpected report, expected none, actual action %0d elapsed %0d",
                   $time, got.action, got.elapsed);
          errs++;
        end else begin
          want = expected_reports.pop_front();
          if (got.action !== want.action) begin
            $display("%0t: action mismatch, expected %0d, actual %0d",
                     $time, want.action, got.action);
            errs++;
          end
          if (got.elapsed !== want.elapsed) begin
            $display("%0t: elapsed_time mismatch, expected %0d, actual %0d",
                     $time, want.elapsed, got.elapsed);
            errs++;
          end
        end
      end
      mismatch_cnt_o <= errs;
      pending_o      <= expected_reports.size();
    end
  end

endmodule

### verif/stream_stall_watchdog_tb.sv
// Testbench top for the stream stall watchdog: clock, reset, stimulus, receiver stalls, verdict.
`timescale 1ns / 1ps

module stream_stall_watchdog_tb;
  import ssw_pkg::*;

  localparam int unsigned      IdleLimit = 4000;
  localparam logic [TimeW-1:0] TimeMax   = '1;
  localparam logic [CfgW-1:0]  CfgMax    = '1;

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we;
  logic [CfgIdxW-1:0]  cfg_idx;
  logic [CfgW-1:0]     cfg_wdata;
  int unsigned         mismatch_cnt;
  int unsigned         pending;
  int unsigned         idle_cycles;
  logic [CfgW-1:0]     thr_now;
  logic [CfgW-1:0]     ivl_now;
  logic [TimeW-1:0]    clock_ms;
  logic                no_gaps;
  int unsigned         burst_left;
  int unsigned         rx_mode = 0;
  int unsigned         rx_left = 0;

  ssw_req_if req_if ();
  ssw_rpt_if rpt_if ();

  stream_stall_watchdog dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (req_if),
    .out_o       (rpt_if),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata)
  );

  stream_stall_watchdog_checker u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .req_mon        (req_if),
    .rpt_mon        (rpt_if),
    .cfg_we_i       (cfg_we),
    .cfg_idx_i      (cfg_idx),
    .cfg_wdata_i    (cfg_wdata),
    .mismatch_cnt_o (mismatch_cnt),
    .pending_o      (pending)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // stall the report side in changing patterns
  always @(posedge clk_i) begin
    if (rx_left == 0) begin
      rx_mode <= $urandom_range(0, 3);
      rx_left <= $urandom_range(32, 400);
    end else begin
      rx_left <= rx_left - 1;
    end
    case (rx_mode)
      0: rpt_if.ready <= 1'b1;
      1: rpt_if.ready <= 1'($urandom_range(0, 1));
      2: rpt_if.ready <= ($urandom_range(0, 3) == 0);
      default: rpt_if.ready <= (rx_left % 5 != 0);
    endcase
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (req_if.valid && req_if.ready) || (rpt_if.valid && rpt_if.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("== FAIL ==");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic send_beat(logic restart, logic [TimeW-1:0] now, logic svalid);
    req_if.valid        <= 1'b1;
    req_if.req_type     <= restart;
    req_if.now_time     <= now;
    req_if.stream_valid <= svalid;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
  endtask

  // end a burst now and then with a random gap
  task automatic pace();
    int unsigned gap;
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      gap = no_gaps ? 0 : $urandom_range(0, 6);
      if (gap != 0) begin
        req_if.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 12);
    end
  endtask

  task automatic drain();
    req_if.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  task automatic cfg_write(logic [CfgIdxW-1:0] idx, logic [CfgW-1:0] val, logic last);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val;
    @(posedge clk_i);
    if (last) cfg_we <= 1'b0;
  endtask

  task automatic set_config(logic [CfgW-1:0] thr, logic [CfgW-1:0] ivl);
    drain();
    cfg_write(RegThreshold, thr, 1'b0);
    cfg_write(RegInterval, ivl, 1'b0);
    cfg_write(CfgIdxW'($urandom_range(RegInterval + 1, (1 << CfgIdxW) - 1)),
              CfgW'($urandom), 1'b1);
    thr_now = thr;
    ivl_now = ivl;
  endtask

  function automatic logic [TimeW-1:0] step_near(logic [TimeW-1:0] x);
    case ($urandom_range(0, 5))
      0: return x;
      1: return (x == 0) ? '0 : x - 1;
      2: return x + 1;
      3: return TimeW'($urandom_range(0, 7));
      4: return x + TimeW'($urandom_range(0, 1000));
      default: return TimeW'($urandom);
    endcase
  endfunction

  task automatic run_phase(int unsigned n_items);
    int unsigned      sent;
    int unsigned      k;
    int unsigned      r;
    logic [TimeW-1:0] x;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(0, 3) == 0) begin
        clock_ms = {$urandom, $urandom};
      end else begin
        clock_ms += TimeW'($urandom_range(0, 100000));
      end
      send_beat(1'b1, clock_ms, 1'($urandom_range(0, 1)));
      pace();
      sent++;
      k = $urandom_range(4, 30);
      repeat (k) begin
        r = $urandom_range(0, 99);
        x = $urandom_range(0, 1) ? TimeW'(thr_now) : TimeW'(ivl_now);
        if (r < 15) begin
          clock_ms += TimeW'($urandom_range(0, 5));
          send_beat(1'b0, clock_ms, 1'b1);
        end else if (r < 80) begin
          clock_ms += step_near(x);
          send_beat(1'b0, clock_ms, 1'b0);
        end else if (r < 88) begin
          clock_ms -= step_near(x);
          send_beat(1'b0, clock_ms, 1'($urandom_range(0, 1)));
        end else if (r < 93) begin
          send_beat(1'($urandom_range(0, 1)), {$urandom, $urandom}, 1'($urandom_range(0, 1)));
        end else if (r < 96) begin
          send_beat(1'b1, clock_ms, 1'($urandom_range(0, 1)));
        end else begin
          send_beat(1'b0, clock_ms, 1'($urandom_range(0, 1)));
        end
        pace();
        sent++;
      end
    end
  endtask

  initial begin
    rst_ni              <= 1'b0;
    req_if.valid        <= 1'b0;
    req_if.req_type     <= 1'b0;
    req_if.now_time     <= '0;
    req_if.stream_valid <= 1'b0;
    cfg_we              <= 1'b0;
    cfg_idx             <= RegThreshold;
    cfg_wdata           <= '0;
    thr_now    = ThresholdReset;
    ivl_now    = IntervalReset;
    clock_ms   = '0;
    no_gaps    = 1'b1;
    burst_left = 1;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    send_beat(1'b0, 64'd1999, 1'b0);
    send_beat(1'b0, 64'd2000, 1'b0);
    send_beat(1'b0, 64'd2001, 1'b0);
    send_beat(1'b0, 64'd12000, 1'b0);
    send_beat(1'b0, 64'd11999, 1'b0);
    send_beat(1'b0, 64'd15000, 1'b1);
    send_beat(1'b0, 64'd16000, 1'b1);
    send_beat(1'b1, TimeMax, 1'b1);
    send_beat(1'b0, 64'd0, 1'b0);
    send_beat(1'b1, 64'd100, 1'b0);
    send_beat(1'b0, TimeMax, 1'b0);
    send_beat(1'b0, TimeMax, 1'b0);
    send_beat(1'b0, 64'd5, 1'b1);
    send_beat(1'b1, 64'd50000, 1'b1);
    send_beat(1'b0, 64'd52000, 1'b0);
    send_beat(1'b0, 64'd40000, 1'b0);
    send_beat(1'b1, 64'd60000, 1'b0);
    send_beat(1'b0, 64'd61000, 1'b0);
    set_config('0, '0);
    send_beat(1'b0, 64'd61000, 1'b0);
    send_beat(1'b0, 64'd61000, 1'b0);
    send_beat(1'b0, 64'd60000, 1'b0);
    send_beat(1'b0, 64'd59000, 1'b1);
    set_config(CfgMax, CfgMax);
    send_beat(1'b0, 64'd59000 + TimeW'(CfgMax) - 1, 1'b0);
    send_beat(1'b0, 64'd59000 + TimeW'(CfgMax), 1'b0);
    send_beat(1'b0, 64'd59000 + 2 * TimeW'(CfgMax), 1'b0);
    send_beat(1'b0, TimeMax, 1'b1);

    for (int p = 0; p < 8; p++) begin
      case (p)
        0: set_config(ThresholdReset, IntervalReset);
        1: set_config('0, '0);
        2: set_config(CfgMax, CfgMax);
        3: set_config(CfgW'(1), CfgW'(3));
        4: set_config(CfgW'($urandom_range(0, 5000)), CfgW'($urandom_range(0, 20000)));
        5: set_config(CfgMax, '0);
        6: set_config('0, CfgMax);
        default: set_config(CfgW'($urandom), CfgW'($urandom));
      endcase
      no_gaps    = ($urandom_range(0, 2) == 0);
      burst_left = $urandom_range(1, 12);
      run_phase(175);
    end

    drain();
    repeat (10) @(posedge clk_i);
    if (mismatch_cnt == 0 && pending == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

### sim.f
hw/rtl/ssw_pkg.sv
hw/rtl/ssw_if.sv
hw/rtl/ssw_cfg.sv
hw/rtl/ssw_eval.sv
hw/rtl/stream_stall_watchdog.sv
verif/stream_stall_watchdog_checker.sv
verif/stream_stall_watchdog_tb.sv
